// ===== hdl/gtdu_pkg.sv =====
`timescale 1ns / 1ps

package gtdu_pkg;

  localparam int PIX_W     = 8;
  localparam int LANES     = 8;
  localparam int SCALE     = 3;
  localparam int BITS_W    = LANES * SCALE;
  localparam int ADDR_W    = 14;
  localparam int ORG_ROW_W = 6;
  localparam int ORG_BYT_W = 5;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 8;
  localparam int K_W       = 2;

  localparam logic [K_W-1:0] K_LAST = K_W'(SCALE - 1);

  localparam logic [PIX_W-1:0] MASK_EVEN = 8'h55;
  localparam logic [PIX_W-1:0] MASK_ODD  = 8'hAA;

  localparam logic [PIX_W-1:0]     DARK_RST    = 8'd0;
  localparam logic [PIX_W-1:0]     LIGHT_RST   = 8'd255;
  localparam logic [ORG_ROW_W-1:0] ORG_ROW_RST = 6'd24;
  localparam logic [ORG_BYT_W-1:0] ORG_BYT_RST = 5'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DARK_LEVEL  = 4'd0,
    REG_LIGHT_LEVEL = 4'd1,
    REG_ORIGIN_ROW  = 4'd2,
    REG_ORIGIN_BYTE = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix_0;
    logic [PIX_W-1:0] pix_1;
    logic [PIX_W-1:0] pix_2;
    logic [PIX_W-1:0] pix_3;
    logic [PIX_W-1:0] pix_4;
    logic [PIX_W-1:0] pix_5;
    logic [PIX_W-1:0] pix_6;
    logic [PIX_W-1:0] pix_7;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [BITS_W-1:0] write_bits;
    logic              group_done;
  } out_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] t_high;
    logic [PIX_W-1:0] t_low;
  } thresh_t;

endpackage

// ===== hdl/gray_threshold_dither_upscale_core.sv =====
`timescale 1ns / 1ps
// After an input transfer, the first of three row writes passes through the stage
// register and then the output register before it is valid.
// The output register sends one row write per cycle while out_ready is high; while it
// sends the three row writes of a group, the next group waits in a stage register.
// Reset (rst_n low at a clock edge) empties the pipeline, zeroes the column and row
// counters and returns the level and origin registers to their default values.
module gray_threshold_dither_upscale_core #(
  parameter int ROW_BYTES  = 52,
  parameter int SRC_WIDTH  = 96,
  parameter int SRC_HEIGHT = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gtdu_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gtdu_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gtdu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gtdu_pkg::CFG_DAT_W-1:0] cfg_data
);
  import gtdu_pkg::*;

  localparam int GROUPS = SRC_WIDTH / 8;
  localparam int COL_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SROW_W = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;

  logic [PIX_W-1:0]     dark_r, light_r;
  logic [ORG_ROW_W-1:0] org_row_r;
  logic [ORG_BYT_W-1:0] org_byte_r;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [SROW_W-1:0]    srow_r, srow_nxt;
  logic                 in_fire;
  thresh_t              thr;
  logic [PIX_W-1:0]     pix_a [LANES];
  logic [PIX_W-1:0]     mask;
  logic [BITS_W-1:0]    bits;
  logic [ADDR_W-1:0]    row_sum;
  logic [ADDR_W-1:0]    col3;
  logic [ADDR_W-1:0]    base_addr;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r     <= DARK_RST;
      light_r    <= LIGHT_RST;
      org_row_r  <= ORG_ROW_RST;
      org_byte_r <= ORG_BYT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DARK_LEVEL:  dark_r     <= cfg_data;
        REG_LIGHT_LEVEL: light_r    <= cfg_data;
        REG_ORIGIN_ROW:  org_row_r  <= cfg_data[ORG_ROW_W-1:0];
        REG_ORIGIN_BYTE: org_byte_r <= cfg_data[ORG_BYT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_nxt  = col_r;
    srow_nxt = srow_r;
    if (in_fire) begin
      if (col_r == COL_W'(GROUPS - 1)) begin
        col_nxt  = '0;
        srow_nxt = (srow_r == SROW_W'(SRC_HEIGHT - 1)) ? '0 : srow_r + SROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      srow_r <= '0;
    end else begin
      col_r  <= col_nxt;
      srow_r <= srow_nxt;
    end
  end

  gtdu_thresh u_thresh (
    .dark_level  (dark_r),
    .light_level (light_r),
    .thr         (thr)
  );

  assign pix_a[0] = in_data.pix_0;
  assign pix_a[1] = in_data.pix_1;
  assign pix_a[2] = in_data.pix_2;
  assign pix_a[3] = in_data.pix_3;
  assign pix_a[4] = in_data.pix_4;
  assign pix_a[5] = in_data.pix_5;
  assign pix_a[6] = in_data.pix_6;
  assign pix_a[7] = in_data.pix_7;

  assign mask = srow_r[0] ? MASK_ODD : MASK_EVEN;

  // Pixel 0 is the leftmost and lands in the most significant bits.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    gtdu_lane u_lane (
      .pix      (pix_a[i]),
      .thr      (thr),
      .mask_bit (mask[LANES-1-i]),
      .white    (bits[BITS_W-1-SCALE*i -: SCALE])
    );
  end

  // Address arithmetic wraps at the address width, as the framebuffer does.
  always_comb begin
    row_sum   = ADDR_W'(org_row_r) + ADDR_W'(srow_r) + (ADDR_W'(srow_r) << 1);
    col3      = ADDR_W'(col_r) + (ADDR_W'(col_r) << 1);
    base_addr = ADDR_W'(row_sum * ADDR_W'(ROW_BYTES)) + ADDR_W'(org_byte_r) + col3;
  end

  gtdu_emit #(
    .ROW_BYTES (ROW_BYTES)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item_bits  (bits),
    .item_addr  (base_addr),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== hdl/gtdu_thresh.sv =====
`timescale 1ns / 1ps

module gtdu_thresh (
  input  logic [gtdu_pkg::PIX_W-1:0] dark_level,
  input  logic [gtdu_pkg::PIX_W-1:0] light_level,
  output gtdu_pkg::thresh_t          thr
);
  import gtdu_pkg::*;

  logic             neg;
  logic [PIX_W-1:0] mag;
  logic [PIX_W+1:0] mag3;
  logic [PIX_W+2:0] mag5;
  logic [PIX_W-1:0] q3;
  logic [PIX_W-1:0] q5;

  // Truncation toward zero: divide the magnitude, then apply the sign.
  always_comb begin
    neg  = light_level < dark_level;
    mag  = neg ? (dark_level - light_level) : (light_level - dark_level);
    mag3 = {2'b00, mag} + {1'b0, mag, 1'b0};
    mag5 = {3'b000, mag} + {1'b0, mag, 2'b00};
    q3   = PIX_W'(mag3 >> 3);
    q5   = PIX_W'(mag5 >> 3);
    thr.t_low  = neg ? (dark_level - q3) : (dark_level + q3);
    thr.t_high = neg ? (dark_level - q5) : (dark_level + q5);
  end

endmodule

// ===== hdl/gtdu_lane.sv =====
`timescale 1ns / 1ps

module gtdu_lane (
  input  logic [gtdu_pkg::PIX_W-1:0] pix,
  input  gtdu_pkg::thresh_t          thr,
  input  logic                       mask_bit,
  output logic [gtdu_pkg::SCALE-1:0] white
);
  import gtdu_pkg::*;

  logic on;

  always_comb begin
    on    = (pix >= thr.t_high) || ((pix >= thr.t_low) && mask_bit);
    white = {SCALE{~on}};
  end

endmodule

// ===== hdl/gtdu_emit.sv =====
`timescale 1ns / 1ps

module gtdu_emit #(
  parameter int ROW_BYTES = 52
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [gtdu_pkg::BITS_W-1:0] item_bits,
  input  logic [gtdu_pkg::ADDR_W-1:0] item_addr,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gtdu_pkg::out_item_t         out_data
);
  import gtdu_pkg::*;

  logic              stage_valid_r, stage_valid_nxt;
  logic [BITS_W-1:0] stage_bits_r;
  logic [ADDR_W-1:0] stage_addr_r;
  logic              out_valid_r, out_valid_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [BITS_W-1:0] bits_r;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              out_fire;
  logic              last_fire;
  logic              load_out;
  logic              in_fire;

  // The stage register holds the next group while the output register is
  // still sending the three row writes of the previous one.
  always_comb begin
    out_fire   = out_valid_r && out_ready;
    last_fire  = out_fire && (k_r == K_LAST);
    load_out   = stage_valid_r && (!out_valid_r || last_fire);
    item_ready = !stage_valid_r || load_out;
    in_fire    = item_valid && item_ready;

    stage_valid_nxt = stage_valid_r;
    if (in_fire) begin
      stage_valid_nxt = 1'b1;
    end else if (load_out) begin
      stage_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    k_nxt         = k_r;
    addr_nxt      = addr_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      k_nxt         = '0;
      addr_nxt      = stage_addr_r;
    end else if (out_fire) begin
      if (k_r == K_LAST) begin
        out_valid_nxt = 1'b0;
      end
      k_nxt    = k_r + K_W'(1);
      addr_nxt = addr_r + ADDR_W'(ROW_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      k_r           <= '0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      k_r           <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_bits_r <= item_bits;
      stage_addr_r <= item_addr;
    end
    if (load_out) begin
      bits_r <= stage_bits_r;
    end
    addr_r <= addr_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_data.write_address = addr_r;
  assign out_data.write_bits    = bits_r;
  assign out_data.group_done    = (k_r == K_LAST);

endmodule

// ===== hdl/gtdu_check.sv =====
`timescale 1ns / 1ps

module gtdu_check #(
  parameter int ROW_BYTES = 52
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input gtdu_pkg::out_item_t out_data
);
  import gtdu_pkg::*;

  logic out_fire;
  assign out_fire = out_valid && out_ready;

  // A result that is not taken holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The three row writes of a group follow without a gap in valid.
  a_group_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_data.group_done |=> out_valid)
    else $error("group ended early");

  // Consecutive rows of a group step by one framebuffer row and repeat the bits.
  a_row_stride: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_data.group_done |=>
      (out_data.write_address == $past(out_data.write_address) + ADDR_W'(ROW_BYTES)) &&
      (out_data.write_bits == $past(out_data.write_bits)))
    else $error("row stride or bits wrong within group");

  // Input is only held off while results are pending.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gray_threshold_dither_upscale_core gtdu_check #(.ROW_BYTES(ROW_BYTES)) u_check (.*);
